/* design/ps2a_pkg.sv */
`timescale 1ns / 1ps
// Package for the PS/2 set-2 scan code to ASCII unit.
// Holds the key code constants, character codes and both character tables.
// It has no dependencies.
package ps2a_pkg;

    localparam int KEY_CODES_DEF = 128;

    localparam logic [7:0] BREAK_CODE  = 8'hF0;
    localparam logic [7:0] LSHIFT_CODE = 8'h12;
    localparam logic [7:0] RSHIFT_CODE = 8'h59;
    localparam logic [7:0] CTRL_CODE   = 8'h14;

    localparam logic [6:0] CHAR_NONE = 7'h00;
    localparam logic [6:0] CHAR_EOT  = 7'h04;
    localparam logic [6:0] CHAR_TAB  = 7'h09;
    localparam logic [6:0] CHAR_C    = 7'h63;
    localparam logic [6:0] CHAR_D    = 7'h64;

    function automatic logic [6:0] lower_char(input logic [7:0] code);
        logic [6:0] ch;
        case (code)
            8'h0D: ch = 7'h09;
            8'h0E: ch = 7'h60;
            8'h15: ch = 7'h71;
            8'h16: ch = 7'h31;
            8'h1A: ch = 7'h7A;
            8'h1B: ch = 7'h73;
            8'h1C: ch = 7'h61;
            8'h1D: ch = 7'h77;
            8'h1E: ch = 7'h32;
            8'h21: ch = 7'h63;
            8'h22: ch = 7'h78;
            8'h23: ch = 7'h64;
            8'h24: ch = 7'h65;
            8'h25: ch = 7'h34;
            8'h26: ch = 7'h33;
            8'h29: ch = 7'h20;
            8'h2A: ch = 7'h76;
            8'h2B: ch = 7'h66;
            8'h2C: ch = 7'h74;
            8'h2D: ch = 7'h72;
            8'h2E: ch = 7'h35;
            8'h31: ch = 7'h6E;
            8'h32: ch = 7'h62;
            8'h33: ch = 7'h68;
            8'h34: ch = 7'h67;
            8'h35: ch = 7'h79;
            8'h36: ch = 7'h36;
            8'h3A: ch = 7'h6D;
            8'h3B: ch = 7'h6A;
            8'h3C: ch = 7'h75;
            8'h3D: ch = 7'h37;
            8'h3E: ch = 7'h38;
            8'h41: ch = 7'h2C;
            8'h42: ch = 7'h6B;
            8'h43: ch = 7'h69;
            8'h44: ch = 7'h6F;
            8'h45: ch = 7'h30;
            8'h46: ch = 7'h39;
            8'h49: ch = 7'h2E;
            8'h4A: ch = 7'h2F;
            8'h4B: ch = 7'h6C;
            8'h4C: ch = 7'h3B;
            8'h4D: ch = 7'h70;
            8'h4E: ch = 7'h2D;
            8'h52: ch = 7'h27;
            8'h54: ch = 7'h5B;
            8'h55: ch = 7'h3D;
            8'h5A: ch = 7'h0D;
            8'h5B: ch = 7'h5D;
            8'h5D: ch = 7'h5C;
            8'h66: ch = 7'h08;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] upper_char(input logic [7:0] code);
        logic [6:0] ch;
        case (code)
            8'h0E: ch = 7'h7E;
            8'h15: ch = 7'h51;
            8'h16: ch = 7'h21;
            8'h1A: ch = 7'h5A;
            8'h1B: ch = 7'h53;
            8'h1C: ch = 7'h41;
            8'h1D: ch = 7'h57;
            8'h1E: ch = 7'h40;
            8'h21: ch = 7'h43;
            8'h22: ch = 7'h58;
            8'h23: ch = 7'h44;
            8'h24: ch = 7'h45;
            8'h25: ch = 7'h24;
            8'h26: ch = 7'h23;
            8'h29: ch = 7'h20;
            8'h2A: ch = 7'h56;
            8'h2B: ch = 7'h46;
            8'h2C: ch = 7'h54;
            8'h2D: ch = 7'h52;
            8'h2E: ch = 7'h25;
            8'h31: ch = 7'h4E;
            8'h32: ch = 7'h42;
            8'h33: ch = 7'h48;
            8'h34: ch = 7'h47;
            8'h35: ch = 7'h59;
            8'h36: ch = 7'h5E;
            8'h3A: ch = 7'h4D;
            8'h3B: ch = 7'h4A;
            8'h3C: ch = 7'h55;
            8'h3D: ch = 7'h26;
            8'h3E: ch = 7'h2A;
            8'h41: ch = 7'h3C;
            8'h42: ch = 7'h4B;
            8'h43: ch = 7'h49;
            8'h44: ch = 7'h4F;
            8'h45: ch = 7'h29;
            8'h46: ch = 7'h28;
            8'h49: ch = 7'h3E;
            8'h4A: ch = 7'h3F;
            8'h4B: ch = 7'h4C;
            8'h4C: ch = 7'h3A;
            8'h4D: ch = 7'h50;
            8'h4E: ch = 7'h5F;
            8'h52: ch = 7'h22;
            8'h54: ch = 7'h7B;
            8'h55: ch = 7'h2B;
            8'h5A: ch = 7'h0D;
            8'h5B: ch = 7'h7D;
            8'h5D: ch = 7'h7C;
            8'h66: ch = 7'h08;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

/* design/ps2a_decoder.sv */
`timescale 1ns / 1ps
// Character lookup for a pressed key, with control and shift handling.
// Depends on ps2a_pkg for the character tables and character codes.
module ps2a_decoder (
    input  logic [7:0] i_code,
    input  logic       i_ctrl_held,
    input  logic       i_shift_held,
    output logic [6:0] o_char
);
    import ps2a_pkg::*;

    logic [6:0] plain;
    logic [6:0] shifted;

    assign plain   = lower_char(i_code);
    assign shifted = upper_char(i_code);

    always_comb begin
        if (i_ctrl_held && (plain == CHAR_C || plain == CHAR_TAB)) begin
            o_char = CHAR_NONE;
        end else if (i_ctrl_held && plain == CHAR_D) begin
            o_char = CHAR_EOT;
        end else if (i_shift_held) begin
            o_char = shifted;
        end else begin
            o_char = plain;
        end
    end

endmodule

/* design/ps2_scan_code_to_ascii_unit.sv */
`timescale 1ns / 1ps
// Top level of the PS/2 set-2 scan code to ASCII unit: input register,
// held-key map, character lookup and output register. Uses ps2a_pkg, ps2a_decoder.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------
//  input   | i_valid / o_ready   | i_scan_code  (8 bits)
//  output  | o_valid / i_ready   | o_ascii_char (7 bits)
//
// A transaction is captured in the input register together with its held-key bit,
// goes through the lookup in the next cycle and is valid at the output when it
// advances. One transaction is accepted per cycle while the output is being taken
// and no clearing pass runs. The held-key map is updated as a transaction moves to
// the output. After reset a clearing pass writes one map entry per cycle until all
// KEY_CODES entries (128 by default) are cleared, with o_ready low. A stalled output
// holds its transaction; the input register then fills and stalls.
module ps2_scan_code_to_ascii_unit #(
    parameter int KEY_CODES = ps2a_pkg::KEY_CODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_ascii_char
);
    import ps2a_pkg::*;

    localparam int IDX_W = $clog2(KEY_CODES);

    logic                 r_in_valid;
    logic [7:0]           r_code;
    logic                 r_held_rd;
    logic                 r_out_valid;
    logic [6:0]           r_ascii;
    logic                 r_key_mem [KEY_CODES];
    logic                 r_clr_busy;
    logic [IDX_W-1:0]     r_clr_idx;
    logic                 r_lshift;
    logic                 r_rshift;
    logic                 r_ctrl;

    logic             advance;
    logic             in_map;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_idx;
    logic             cur_held;
    logic             release_key;
    logic             press_key;
    logic             wr_en;
    logic             is_modifier;
    logic             ctrl_held;
    logic             shift_held;
    logic [6:0]       dec_char;
    logic [6:0]       n_ascii;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_in_valid || advance);
    assign o_valid = r_out_valid;
    assign o_ascii_char = r_ascii;

    assign in_map = (r_code != BREAK_CODE) && ({1'b0, r_code} < 9'(KEY_CODES));
    assign idx = r_code[IDX_W-1:0];
    assign rd_idx = i_scan_code[IDX_W-1:0];
    assign cur_held = in_map ? r_held_rd : 1'b0;
    assign release_key = in_map && (r_code != 8'h00) && cur_held;
    assign press_key = in_map && !release_key;
    assign wr_en = advance && in_map;
    assign is_modifier = (r_code == LSHIFT_CODE) || (r_code == RSHIFT_CODE)
                         || (r_code == CTRL_CODE);

    assign ctrl_held  = r_ctrl;
    assign shift_held = r_lshift || r_rshift;

    ps2a_decoder u_decoder (
        .i_code       (r_code),
        .i_ctrl_held  (ctrl_held),
        .i_shift_held (shift_held),
        .o_char       (dec_char)
    );

    assign n_ascii = (press_key && !is_modifier) ? dec_char : CHAR_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_lshift    <= 1'b0;
            r_rshift    <= 1'b0;
            r_ctrl      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(KEY_CODES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (wr_en) begin
                if (r_code == LSHIFT_CODE) begin
                    r_lshift <= press_key;
                end
                if (r_code == RSHIFT_CODE) begin
                    r_rshift <= press_key;
                end
                if (r_code == CTRL_CODE) begin
                    r_ctrl <= press_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code <= i_scan_code;
            if (wr_en && rd_idx == idx) begin
                r_held_rd <= press_key;
            end else begin
                r_held_rd <= r_key_mem[rd_idx];
            end
        end
        if (advance) begin
            r_ascii <= n_ascii;
        end
        if (r_clr_busy) begin
            r_key_mem[r_clr_idx] <= 1'b0;
        end else if (wr_en) begin
            r_key_mem[idx] <= press_key;
        end
    end

endmodule

/* tb/tb_ps2_scan_code_to_ascii_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ps2_scan_code_to_ascii_unit with its own held-key decoder model.
// Drives key press and release sequences, checks every output transaction. Uses ps2a_pkg.
module tb_ps2_scan_code_to_ascii_unit;
    import ps2a_pkg::*;

    localparam int KEY_MAP_SIZE = KEY_CODES_DEF;
    localparam int ROM_DEPTH = 112;
    localparam int ITEM_TARGET = 1550;
    localparam int LONG_STALL = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS = 100;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam logic [0:ROM_DEPTH-1][6:0] LOWER_MAP = {
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h09, 7'h60, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h71, 7'h31, 7'h00,
        7'h00, 7'h00, 7'h7A, 7'h73, 7'h61, 7'h77, 7'h32, 7'h00,
        7'h00, 7'h63, 7'h78, 7'h64, 7'h65, 7'h34, 7'h33, 7'h00,
        7'h00, 7'h20, 7'h76, 7'h66, 7'h74, 7'h72, 7'h35, 7'h00,
        7'h00, 7'h6E, 7'h62, 7'h68, 7'h67, 7'h79, 7'h36, 7'h00,
        7'h00, 7'h00, 7'h6D, 7'h6A, 7'h75, 7'h37, 7'h38, 7'h00,
        7'h00, 7'h2C, 7'h6B, 7'h69, 7'h6F, 7'h30, 7'h39, 7'h00,
        7'h00, 7'h2E, 7'h2F, 7'h6C, 7'h3B, 7'h70, 7'h2D, 7'h00,
        7'h00, 7'h00, 7'h27, 7'h00, 7'h5B, 7'h3D, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h0D, 7'h5D, 7'h00, 7'h5C, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [0:ROM_DEPTH-1][6:0] UPPER_MAP = {
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7E, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h51, 7'h21, 7'h00,
        7'h00, 7'h00, 7'h5A, 7'h53, 7'h41, 7'h57, 7'h40, 7'h00,
        7'h00, 7'h43, 7'h58, 7'h44, 7'h45, 7'h24, 7'h23, 7'h00,
        7'h00, 7'h20, 7'h56, 7'h46, 7'h54, 7'h52, 7'h25, 7'h00,
        7'h00, 7'h4E, 7'h42, 7'h48, 7'h47, 7'h59, 7'h5E, 7'h00,
        7'h00, 7'h00, 7'h4D, 7'h4A, 7'h55, 7'h26, 7'h2A, 7'h00,
        7'h00, 7'h3C, 7'h4B, 7'h49, 7'h4F, 7'h29, 7'h28, 7'h00,
        7'h00, 7'h3E, 7'h3F, 7'h4C, 7'h3A, 7'h50, 7'h5F, 7'h00,
        7'h00, 7'h00, 7'h22, 7'h00, 7'h7B, 7'h2B, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h0D, 7'h7D, 7'h00, 7'h7C, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_scan_code = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [6:0] o_ascii_char;

    logic [7:0] scan_queue[$];
    logic [6:0] expected_chars[$];
    logic [KEY_MAP_SIZE-1:0] held_keys = '0;
    int         accepted_count = 0;
    int         mismatch_count = 0;
    int         burst_left = 8;
    int         gap_left = 0;
    rx_mode_t   rx_mode = RX_ALWAYS;
    int         rx_mode_left = 64;
    int         rx_cycle = 0;
    logic       hold_off = 1'b0;

    ps2_scan_code_to_ascii_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_scan_code  (i_scan_code),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char)
    );

    function automatic logic [6:0] decode_key(input logic [7:0] code);
        logic [6:0] plain;
        logic [6:0] shifted;
        if (code == BREAK_CODE || code >= KEY_MAP_SIZE) return CHAR_NONE;
        if (code != '0 && held_keys[code]) begin
            held_keys[code] = 1'b0;
            return CHAR_NONE;
        end
        held_keys[code] = 1'b1;
        if (code == LSHIFT_CODE || code == RSHIFT_CODE || code == CTRL_CODE) return CHAR_NONE;
        plain = (code < ROM_DEPTH) ? LOWER_MAP[code] : CHAR_NONE;
        shifted = (code < ROM_DEPTH) ? UPPER_MAP[code] : CHAR_NONE;
        if (held_keys[CTRL_CODE]) begin
            if (plain == CHAR_C || plain == CHAR_TAB) return CHAR_NONE;
            if (plain == CHAR_D) return CHAR_EOT;
        end
        if (held_keys[LSHIFT_CODE] || held_keys[RSHIFT_CODE]) return shifted;
        return plain;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0 || scan_queue.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                i_valid <= 1'b1;
                i_scan_code <= scan_queue.pop_front();
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    always @(posedge i_clk) begin : rx_side
        logic open;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(32, 256);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            rx_cycle <= rx_cycle + 1;
            case (rx_mode)
                RX_ALWAYS:   open = 1'b1;
                RX_COIN:     open = 1'($urandom_range(0, 1));
                RX_MOSTLY:   open = ($urandom_range(0, 9) != 0);
                RX_PERIODIC: open = (rx_cycle % 5 < 2);
                default:     open = 1'b1;
            endcase
            i_ready <= !hold_off && open;
        end
    end

    initial begin
        while (accepted_count < 300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (LONG_STALL) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_keys = '0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected output transaction, expected none, got %02h",
                                 $time, o_ascii_char);
                end else if (expected_chars[0] !== o_ascii_char) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t ns: ascii_char mismatch, expected %02h, got %02h",
                                 $time, expected_chars[0], o_ascii_char);
                    void'(expected_chars.pop_front());
                end else begin
                    void'(expected_chars.pop_front());
                end
            end
            if (i_valid && o_ready) begin
                expected_chars.push_back(decode_key(i_scan_code));
                accepted_count++;
            end
        end
    end

    initial begin
        logic [7:0] key;
        logic [7:0] shift_key;
        logic [7:0] noise;
        int         counted;
        int         pick;
        int         shift_sel;
        bit         with_ctrl;

        // Code zero, ignored bytes, an unmapped code, then plain, shifted and control keys.
        scan_queue = '{8'h00, 8'h00, BREAK_CODE, 8'hFF, 8'h80, 8'h7F, 8'h7F,
                       8'h1C, 8'h1C,
                       LSHIFT_CODE, 8'h1C, 8'h1C, LSHIFT_CODE,
                       RSHIFT_CODE, 8'h16, 8'h16, RSHIFT_CODE,
                       CTRL_CODE, 8'h21, 8'h21, 8'h0D, 8'h0D, 8'h23, 8'h23, CTRL_CODE};
        counted = 25;

        while (counted < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if ($urandom_range(0, 4) != 0) begin
                    key = 8'($urandom_range(0, ROM_DEPTH - 1));
                    while (LOWER_MAP[key] == CHAR_NONE)
                        key = 8'($urandom_range(0, ROM_DEPTH - 1));
                end else begin
                    key = 8'($urandom_range(0, KEY_MAP_SIZE - 1));
                end
                shift_sel = $urandom_range(0, 3);
                shift_key = (shift_sel == 3) ? RSHIFT_CODE : LSHIFT_CODE;
                with_ctrl = ($urandom_range(0, 3) == 0);
                if (with_ctrl) scan_queue.push_back(CTRL_CODE);
                if (shift_sel >= 2) scan_queue.push_back(shift_key);
                scan_queue.push_back(key);
                scan_queue.push_back(BREAK_CODE);
                scan_queue.push_back(key);
                counted += 3;
                if (shift_sel >= 2) begin
                    scan_queue.push_back(BREAK_CODE);
                    scan_queue.push_back(shift_key);
                    counted += 3;
                end
                if (with_ctrl) begin
                    scan_queue.push_back(BREAK_CODE);
                    scan_queue.push_back(CTRL_CODE);
                    counted += 3;
                end
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 3)) begin
                    scan_queue.push_back(8'($urandom_range(0, KEY_MAP_SIZE - 1)));
                    counted++;
                end
            end else begin
                noise = ($urandom_range(0, 3) == 0) ? BREAK_CODE : 8'($urandom_range(0, 255));
                scan_queue.push_back(noise);
                counted++;
            end
        end

        @(posedge i_rst_n);
        while (scan_queue.size() != 0 || i_valid) @(negedge i_clk);
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
